// ===== rtl/core/fifo_job_to_earliest_server_dispatch_core_defines.svh =====
// ----------------------------------------------------------------------------
// Dispatch core assertion macros
// Shared same-cycle and next-cycle implication forms for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef FIFO_JOB_TO_EARLIEST_SERVER_DISPATCH_CORE_DEFINES_SVH
`define FIFO_JOB_TO_EARLIEST_SERVER_DISPATCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FJD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define FJD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fjd_pkg.sv =====
// ----------------------------------------------------------------------------
// fjd_pkg
// Sizes, codes and controller/datapath link types of the dispatch core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fjd_pkg;

  localparam int NUM_SERVERS = 3;
  localparam int TABLE_SLOTS = 16;
  localparam int QUEUE_DEPTH = 16;

  localparam int OP_W    = 2;
  localparam int ID_W    = 16;
  localparam int RC_W    = 3;
  localparam int SID_W   = 4;
  localparam int TIME_W  = 16;
  localparam int ST_W    = 2;
  localparam int DELAY_W = 10;

  localparam int SLOT_IW = $clog2(TABLE_SLOTS);
  localparam int Q_IW    = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = Q_IW + 1;
  localparam int SRV_IW  = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd30;
  // server i comes out of reset free at TIME_STEP * i
  localparam int TIME_STEP = 5;

  localparam logic [OP_W-1:0] OP_PLACE    = 2'd0;
  localparam logic [OP_W-1:0] OP_ASSIGN   = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPLETE = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY    = 2'd3;

  localparam logic [RC_W-1:0] RC_OK         = 3'd0;
  localparam logic [RC_W-1:0] RC_EMPTY      = 3'd1;
  localparam logic [RC_W-1:0] RC_NOT_FOUND  = 3'd2;
  localparam logic [RC_W-1:0] RC_TABLE_FULL = 3'd3;
  localparam logic [RC_W-1:0] RC_QUEUE_FULL = 3'd4;

  localparam logic [ST_W-1:0] ST_UNKNOWN   = 2'd0;
  localparam logic [ST_W-1:0] ST_PENDING   = 2'd1;
  localparam logic [ST_W-1:0] ST_ACTIVE    = 2'd2;
  localparam logic [ST_W-1:0] ST_DELIVERED = 2'd3;

  typedef struct packed {
    logic load;   // capture the accepted request
    logic match;  // register the table match vector, start server scan
    logic scan;   // visit one more server
    logic exec;   // commit the operation and load the result
  } cmd_t;

  typedef struct packed {
    logic is_assign;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/fjd_ram.sv =====
// ----------------------------------------------------------------------------
// fjd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fjd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/fjd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fjd_ctrl
// Sequencer: accept, match, server scan, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fjd_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  fjd_pkg::sts_t sts,
  output fjd_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match = 1'b1;
        if (sts.is_assign && (fjd_pkg::NUM_SERVERS > 1)) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== rtl/core/fjd_datapath.sv =====
// ----------------------------------------------------------------------------
// fjd_datapath
// Job queue, status table, server free times and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fjd_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fjd_pkg::cmd_t                      cmd,
  output fjd_pkg::sts_t                      sts,
  input  logic [fjd_pkg::OP_W-1:0]           in_operation,
  input  logic [fjd_pkg::ID_W-1:0]           in_job_id,
  input  logic                               cfg_we,
  input  logic [fjd_pkg::DELAY_W-1:0]        cfg_service_delay,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fjd_pkg::RC_W-1:0]           out_result_code,
  output logic [fjd_pkg::ID_W-1:0]           out_job_out,
  output logic [fjd_pkg::SID_W-1:0]          out_server_id,
  output logic [fjd_pkg::TIME_W-1:0]         out_server_time,
  output logic [fjd_pkg::ST_W-1:0]           out_job_status
);

  localparam int NS = fjd_pkg::NUM_SERVERS;
  localparam int TS = fjd_pkg::TABLE_SLOTS;
  localparam int QD = fjd_pkg::QUEUE_DEPTH;

  // request
  logic [fjd_pkg::OP_W-1:0]    op_r;
  logic [fjd_pkg::ID_W-1:0]    id_r;
  logic [fjd_pkg::DELAY_W-1:0] delay_r;

  // queue
  logic [fjd_pkg::Q_IW-1:0]    head_r;
  logic [fjd_pkg::QCNT_W-1:0]  count_r;
  logic [fjd_pkg::ID_W-1:0]    ram_rdata;
  logic                        ram_we;
  logic [fjd_pkg::Q_IW-1:0]    tail;
  logic [fjd_pkg::QCNT_W-1:0]  tail_sum;
  logic [fjd_pkg::Q_IW-1:0]    head_inc;
  logic                        q_full;
  logic                        q_empty;

  // status table
  logic [fjd_pkg::ID_W-1:0]    slot_id_r [TS];
  logic [TS-1:0]               slot_vld_r;
  logic [fjd_pkg::ST_W-1:0]    slot_st_r [TS];
  logic [TS-1:0]               match_r;
  logic [TS-1:0]               match_nxt;
  logic [fjd_pkg::ID_W-1:0]    key;
  logic [fjd_pkg::SLOT_IW-1:0] hit_idx;
  logic [fjd_pkg::SLOT_IW-1:0] free_idx;
  logic [fjd_pkg::SLOT_IW-1:0] place_idx;
  logic                        hit_any;
  logic                        free_any;
  logic                        place_ok;

  // servers
  logic [fjd_pkg::TIME_W-1:0]  sft_r [NS];
  logic [fjd_pkg::SRV_IW-1:0]  scan_r;
  logic [fjd_pkg::SRV_IW-1:0]  best_idx_r;
  logic [fjd_pkg::TIME_W-1:0]  best_time_r;
  logic [fjd_pkg::TIME_W:0]    time_sum;
  logic [fjd_pkg::TIME_W-1:0]  time_nxt;

  // result
  logic                        out_valid_r;
  logic [fjd_pkg::RC_W-1:0]    rc_r;
  logic [fjd_pkg::ID_W-1:0]    job_r;
  logic [fjd_pkg::SID_W-1:0]   sid_r;
  logic [fjd_pkg::TIME_W-1:0]  stime_r;
  logic [fjd_pkg::ST_W-1:0]    st_r;

  // ---------------------------------------------------------------- queue
  assign q_full   = (count_r == fjd_pkg::QCNT_W'(QD));
  assign q_empty  = (count_r == '0);
  assign tail_sum = fjd_pkg::QCNT_W'(head_r) + count_r;
  assign tail     = (tail_sum >= fjd_pkg::QCNT_W'(QD)) ?
                    fjd_pkg::Q_IW'(tail_sum - fjd_pkg::QCNT_W'(QD)) :
                    fjd_pkg::Q_IW'(tail_sum);
  assign head_inc = (head_r == fjd_pkg::Q_IW'(QD - 1)) ? '0 : head_r + 1'b1;

  fjd_ram #(
    .WIDTH (fjd_pkg::ID_W),
    .DEPTH (QD)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (id_r),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- table
  // assign looks up the job at the queue head, other requests their own id
  assign key = (op_r == fjd_pkg::OP_ASSIGN) ? ram_rdata : id_r;

  always_comb begin
    for (int i = 0; i < TS; i++) begin
      match_nxt[i] = slot_vld_r[i] && (slot_id_r[i] == key);
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = fjd_pkg::SLOT_IW'(i);
      end
      if (!slot_vld_r[i]) begin
        free_idx = fjd_pkg::SLOT_IW'(i);
      end
    end
  end

  assign hit_any   = |match_r;
  assign free_any  = ~&slot_vld_r;
  assign place_idx = hit_any ? hit_idx : free_idx;
  assign place_ok  = !q_full && (hit_any || free_any);
  assign ram_we    = cmd.exec && (op_r == fjd_pkg::OP_PLACE) && place_ok;

  // ---------------------------------------------------------------- servers
  assign time_sum = {1'b0, best_time_r} + (fjd_pkg::TIME_W + 1)'(delay_r);
  assign time_nxt = time_sum[fjd_pkg::TIME_W] ? '1 : time_sum[fjd_pkg::TIME_W-1:0];

  // ---------------------------------------------------------------- status
  assign sts.is_assign = (op_r == fjd_pkg::OP_ASSIGN);
  assign sts.scan_last = (scan_r == fjd_pkg::SRV_IW'(NS - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      id_r <= in_job_id;
    end
    if (cmd.match) begin
      match_r     <= match_nxt;
      best_idx_r  <= '0;
      best_time_r <= sft_r[0];
      scan_r      <= fjd_pkg::SRV_IW'(1);
    end
    if (cmd.scan) begin
      // strict less-than keeps the lower server on a tie
      if (sft_r[scan_r] < best_time_r) begin
        best_idx_r  <= scan_r;
        best_time_r <= sft_r[scan_r];
      end
      scan_r <= scan_r + 1'b1;
    end
    if (ram_we) begin
      slot_id_r[place_idx] <= id_r;
    end
    if (cmd.exec) begin
      rc_r    <= fjd_pkg::RC_OK;
      job_r   <= id_r;
      sid_r   <= '0;
      stime_r <= '0;
      st_r    <= fjd_pkg::ST_UNKNOWN;
      unique case (op_r)
        fjd_pkg::OP_PLACE: begin
          if (q_full) begin
            rc_r <= fjd_pkg::RC_QUEUE_FULL;
          end else if (!place_ok) begin
            rc_r <= fjd_pkg::RC_TABLE_FULL;
          end else begin
            st_r <= fjd_pkg::ST_PENDING;
          end
        end
        fjd_pkg::OP_ASSIGN: begin
          if (q_empty) begin
            rc_r  <= fjd_pkg::RC_EMPTY;
            job_r <= '0;
          end else begin
            job_r   <= ram_rdata;
            sid_r   <= fjd_pkg::SID_W'(best_idx_r);
            stime_r <= best_time_r;
            st_r    <= fjd_pkg::ST_ACTIVE;
          end
        end
        fjd_pkg::OP_COMPLETE: begin
          if (hit_any) begin
            st_r <= fjd_pkg::ST_DELIVERED;
          end else begin
            rc_r <= fjd_pkg::RC_NOT_FOUND;
          end
        end
        fjd_pkg::OP_QUERY: begin
          if (hit_any) begin
            st_r <= slot_st_r[hit_idx];
          end else begin
            rc_r <= fjd_pkg::RC_NOT_FOUND;
          end
        end
        default: rc_r <= fjd_pkg::RC_OK;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= fjd_pkg::DELAY_RESET;
      head_r      <= '0;
      count_r     <= '0;
      slot_vld_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TS; i++) begin
        slot_st_r[i] <= fjd_pkg::ST_UNKNOWN;
      end
      for (int i = 0; i < NS; i++) begin
        sft_r[i] <= fjd_pkg::TIME_W'(fjd_pkg::TIME_STEP * i);
      end
    end else begin
      if (cfg_we) begin
        delay_r <= cfg_service_delay;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        count_r               <= count_r + 1'b1;
        slot_vld_r[place_idx] <= 1'b1;
        slot_st_r[place_idx]  <= fjd_pkg::ST_PENDING;
      end
      if (cmd.exec && (op_r == fjd_pkg::OP_ASSIGN) && !q_empty) begin
        head_r            <= head_inc;
        count_r           <= count_r - 1'b1;
        sft_r[best_idx_r] <= time_nxt;
        if (hit_any) begin
          slot_st_r[hit_idx] <= fjd_pkg::ST_ACTIVE;
        end
      end
      if (cmd.exec && (op_r == fjd_pkg::OP_COMPLETE) && hit_any) begin
        slot_st_r[hit_idx] <= fjd_pkg::ST_DELIVERED;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_code = rc_r;
  assign out_job_out     = job_r;
  assign out_server_id   = sid_r;
  assign out_server_time = stime_r;
  assign out_job_status  = st_r;

endmodule

// ===== rtl/core/fifo_job_to_earliest_server_dispatch_core.sv =====
// ----------------------------------------------------------------------------
// fifo_job_to_earliest_server_dispatch_core
// Job queue with status table and earliest-free server assignment.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall with an operation (place, assign,
// complete, query) and a job id; one result leaves on out_valid/out_stall
// for every request. cfg_valid/cfg_ready writes the service delay; ready is
// always high, and writes belong between requests.
// A request is taken only while the sequencer is idle. Each request is
// captured, then its 16-way table compare is registered; an assign then
// scans the remaining servers for the earliest free time, and every request
// ends in a commit that loads the output register, which drives out_valid.
// The result sits in an output register, so a new request is taken while
// it waits; if out_stall still holds when the next request reaches commit,
// the sequencer waits there and in_stall stays high.
// Reset clears the queue, the table valid bits and statuses, sets server
// free times to 0, 5, 10 and the service delay to 30. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fifo_job_to_earliest_server_dispatch_core_defines.svh"

module fifo_job_to_earliest_server_dispatch_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fjd_pkg::OP_W-1:0]    in_operation,
  input  logic [fjd_pkg::ID_W-1:0]    in_job_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fjd_pkg::RC_W-1:0]    out_result_code,
  output logic [fjd_pkg::ID_W-1:0]    out_job_out,
  output logic [fjd_pkg::SID_W-1:0]   out_server_id,
  output logic [fjd_pkg::TIME_W-1:0]  out_server_time,
  output logic [fjd_pkg::ST_W-1:0]    out_job_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fjd_pkg::DELAY_W-1:0] cfg_service_delay
);

  fjd_pkg::cmd_t cmd;
  fjd_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  fjd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fjd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_job_id         (in_job_id),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_service_delay (cfg_service_delay),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_code   (out_result_code),
    .out_job_out       (out_job_out),
    .out_server_id     (out_server_id),
    .out_server_time   (out_server_time),
    .out_job_status    (out_job_status)
  );

  `FJD_ASSERT_NEXT(a_accept_blocks, clk, rst_n, in_valid && !in_stall, in_stall, "request taken while busy")
  `FJD_ASSERT_NOW(a_commit_free, clk, rst_n, cmd.exec, !(out_valid && out_stall), "commit over a stalled result")
  `FJD_ASSERT_NEXT(a_commit_shows, clk, rst_n, cmd.exec, out_valid, "commit without result")
  `FJD_ASSERT_NOW(a_one_cmd, clk, rst_n, 1'b1, $onehot0({cmd.load, cmd.match, cmd.scan, cmd.exec}), "overlapping commands")

endmodule

// ===== verif/fifo_job_to_earliest_server_dispatch_core_test.sv =====
// ----------------------------------------------------------------------------
// fifo_job_to_earliest_server_dispatch_core_test
// Self-checking bench for the job dispatch core. A scoreboard predicts every
// result from the requests that the core accepts. It tracks the job queue,
// the status table and the server free times, and compares each result
// field by field. The run starts with a directed pass over empty, full,
// unknown and re-placed jobs. Random traffic follows over several service
// delays, with bursts of idle requests and of receiver stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_job_to_earliest_server_dispatch_core_test;
  import fjd_pkg::*;

  typedef struct packed {
    logic [RC_W-1:0]   code;
    logic [ID_W-1:0]   job;
    logic [SID_W-1:0]  server;
    logic [TIME_W-1:0] stime;
    logic [ST_W-1:0]   status;
  } dispatch_result_t;

  class dispatch_scoreboard;
    logic [ID_W-1:0]    queued_jobs[$];
    logic [ID_W-1:0]    slot_job[TABLE_SLOTS];
    bit                 slot_used[TABLE_SLOTS];
    logic [ST_W-1:0]    slot_state[TABLE_SLOTS];
    logic [TIME_W-1:0]  free_time[NUM_SERVERS];
    logic [DELAY_W-1:0] service_delay;
    dispatch_result_t   pending_results[$];
    int mismatches;
    int code_hits[5];
    int ties;
    int saturations;

    function new();
      int i;
      for (i = 0; i < TABLE_SLOTS; i++) begin
        slot_used[i] = 0;
        slot_state[i] = ST_UNKNOWN;
        slot_job[i] = '0;
      end
      for (i = 0; i < NUM_SERVERS; i++) free_time[i] = TIME_W'(TIME_STEP * i);
      service_delay = DELAY_RESET;
      mismatches = 0;
      ties = 0;
      saturations = 0;
      for (i = 0; i < 5; i++) code_hits[i] = 0;
    endfunction

    function void set_delay(logic [DELAY_W-1:0] d);
      service_delay = d;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function int slot_of(logic [ID_W-1:0] id);
      int i;
      for (i = 0; i < TABLE_SLOTS; i++)
        if (slot_used[i] && slot_job[i] == id) return i;
      return -1;
    endfunction

    function int open_slot();
      int i;
      for (i = 0; i < TABLE_SLOTS; i++)
        if (!slot_used[i]) return i;
      return -1;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
      dispatch_result_t r;
      int s;
      int best;
      int i;
      logic [TIME_W:0] next_time;
      r = '0;
      r.code = RC_OK;
      r.job = id;
      r.status = ST_UNKNOWN;
      case (op)
        OP_PLACE: begin
          if (queued_jobs.size() >= QUEUE_DEPTH) begin
            r.code = RC_QUEUE_FULL;
          end else begin
            s = slot_of(id);
            if (s < 0) s = open_slot();
            if (s < 0) begin
              r.code = RC_TABLE_FULL;
            end else begin
              queued_jobs.insert(queued_jobs.size(), id);
              slot_job[s] = id;
              slot_used[s] = 1;
              slot_state[s] = ST_PENDING;
              r.status = ST_PENDING;
            end
          end
        end
        OP_ASSIGN: begin
          if (queued_jobs.size() == 0) begin
            r.code = RC_EMPTY;
            r.job = '0;
          end else begin
            r.job = queued_jobs.pop_front();
            best = 0;
            for (i = 1; i < NUM_SERVERS; i++)
              if (free_time[i] < free_time[best]) best = i;
            for (i = best + 1; i < NUM_SERVERS; i++)
              if (free_time[i] == free_time[best]) ties++;
            r.server = SID_W'(best);
            r.stime = free_time[best];
            next_time = {1'b0, free_time[best]} + (TIME_W + 1)'(service_delay);
            // saturate at the top of the time range
            if (next_time[TIME_W]) saturations++;
            free_time[best] = next_time[TIME_W] ? '1 : next_time[TIME_W-1:0];
            s = slot_of(r.job);
            if (s >= 0) slot_state[s] = ST_ACTIVE;
            r.status = ST_ACTIVE;
          end
        end
        OP_COMPLETE: begin
          s = slot_of(id);
          if (s < 0) begin
            r.code = RC_NOT_FOUND;
          end else begin
            slot_state[s] = ST_DELIVERED;
            r.status = ST_DELIVERED;
          end
        end
        default: begin
          s = slot_of(id);
          if (s < 0) r.code = RC_NOT_FOUND;
          else r.status = slot_state[s];
        end
      endcase
      code_hits[r.code]++;
      pending_results.insert(pending_results.size(), r);
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(dispatch_result_t got);
      dispatch_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.code !== want.code)
          report_mismatch($sformatf("result_code %0d, want %0d", got.code, want.code));
        if (got.job !== want.job)
          report_mismatch($sformatf("job_out %h, want %h", got.job, want.job));
        if (got.server !== want.server)
          report_mismatch($sformatf("server_id %0d, want %0d", got.server, want.server));
        if (got.stime !== want.stime)
          report_mismatch($sformatf("server_time %0d, want %0d", got.stime, want.stime));
        if (got.status !== want.status)
          report_mismatch($sformatf("job_status %0d, want %0d", got.status, want.status));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_operation;
  logic [ID_W-1:0]      in_job_id;
  logic                 out_valid;
  logic                 out_stall;
  logic [RC_W-1:0]      out_result_code;
  logic [ID_W-1:0]      out_job_out;
  logic [SID_W-1:0]     out_server_id;
  logic [TIME_W-1:0]    out_server_time;
  logic [ST_W-1:0]      out_job_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [DELAY_W-1:0]   cfg_service_delay;

  dispatch_scoreboard sb;
  logic [ID_W-1:0] job_pool[TABLE_SLOTS];
  bit calm;
  int requests_sent;

  fifo_job_to_earliest_server_dispatch_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_job_id         (in_job_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_code   (out_result_code),
    .out_job_out       (out_job_out),
    .out_server_id     (out_server_id),
    .out_server_time   (out_server_time),
    .out_job_status    (out_job_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_service_delay (cfg_service_delay)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    in_valid <= 1'b1;
    in_operation <= op;
    in_job_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, id);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_service_delay <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_delay(d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit in_pool(input logic [ID_W-1:0] id);
    int i;
    for (i = 0; i < TABLE_SLOTS; i++)
      if (job_pool[i] == id) return 1;
    return 0;
  endfunction

  task automatic random_request();
    int pick;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = OP_PLACE;
    else if (pick < 80) op = OP_ASSIGN;
    else if (pick < 90) op = OP_COMPLETE;
    else op = OP_QUERY;
    // mostly known jobs; a stray id now and then
    id = job_pool[$urandom_range(0, TABLE_SLOTS - 1)];
    if (op == OP_ASSIGN || $urandom_range(0, 4) == 0) id = ID_W'($urandom());
    send_request(op, id);
  endtask

  // Receiver stalls in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_result_code, out_job_out, out_server_id,
                       out_server_time, out_job_status});
  end

  initial begin
    int phase;
    int i;
    int n;
    logic [DELAY_W-1:0] setting;
    logic [ID_W-1:0] stray;
    sb = new();
    requests_sent = 0;
    calm = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_PLACE;
    in_job_id = '0;
    cfg_valid = 1'b0;
    cfg_service_delay = '0;

    // Pool of distinct ids that fills the table exactly, extremes included
    job_pool[0] = '0;
    job_pool[1] = '1;
    for (i = 2; i < TABLE_SLOTS; i++) begin
      stray = '0;
      while (in_pool(stray)) stray = ID_W'($urandom());
      job_pool[i] = stray;
    end
    stray = '0;
    while (in_pool(stray)) stray = ID_W'($urandom());

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    send_request(OP_ASSIGN, '0);          // nothing queued yet
    send_request(OP_QUERY, job_pool[0]);
    send_request(OP_COMPLETE, job_pool[1]);
    for (i = 0; i < TABLE_SLOTS; i++) send_request(OP_PLACE, job_pool[i]);
    send_request(OP_PLACE, job_pool[0]);  // queue is full
    send_request(OP_ASSIGN, '1);
    send_request(OP_PLACE, stray);        // table has no free slot
    send_request(OP_PLACE, job_pool[0]);  // overwrite back to pending
    send_request(OP_COMPLETE, job_pool[1]);
    send_request(OP_QUERY, job_pool[1]);
    send_request(OP_QUERY, job_pool[0]);
    send_request(OP_QUERY, stray);

    for (phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: setting = DELAY_W'(5);
        2: setting = '0;
        4: setting = DELAY_W'($urandom_range(1, 1022));
        default: setting = '1;
      endcase
      write_delay(setting);
      calm = (phase == 2 || phase == 7);
      for (n = 0; n < 170; n++) begin
        if (!calm && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 13));
        random_request();
      end
    end

    drain();
    if (sb.outstanding() != 0) sb.report_mismatch("results still outstanding at end");
    $display("covered %0d requests over 8 delay phases: ok %0d, empty %0d, not found %0d,",
             requests_sent, sb.code_hits[0], sb.code_hits[1], sb.code_hits[2]);
    $display("table full %0d, queue full %0d; %0d server ties, %0d saturations, %0d mismatches",
             sb.code_hits[3], sb.code_hits[4], sb.ties, sb.saturations, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fjd_pkg.sv
rtl/core/fjd_ram.sv
rtl/core/fjd_ctrl.sv
rtl/core/fjd_datapath.sv
rtl/core/fifo_job_to_earliest_server_dispatch_core.sv
verif/fifo_job_to_earliest_server_dispatch_core_test.sv
